FILE: hdl/psus_pkg.sv
// Shared types and constants of the pendulum swing-up sequencer.
package psus_pkg;

  // Mode codes as reported in state_code
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SWING  = 2'd1,
    MODE_BAL    = 2'd2,
    MODE_FALLEN = 2'd3
  } mode_t;

  // Swing-up phase codes as reported in swing_phase
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_PRE  = 4'd1,
    PH_ICW  = 4'd2,
    PH_ICCW = 4'd3,
    PH_SCAN = 4'd4,
    PH_RCW  = 4'd5,
    PH_RCCW = 4'd6,
    PH_LCCW = 4'd7,
    PH_LCW  = 4'd8
  } phase_t;

  // Register indexes (byte address 4*index)
  typedef enum logic [2:0] {
    REG_UPRIGHT_REF  = 3'd0,
    REG_SWING_DRIVE  = 3'd1,
    REG_PULSE_MS     = 3'd2,
    REG_SAMPLE_MS    = 3'd3,
    REG_PRECHECK_MS  = 3'd4,
    REG_CENTER_RANGE = 3'd5,
    REG_BOTTOM_RANGE = 3'd6,
    REG_TIMEOUT_MS   = 3'd7
  } reg_idx_t;

  localparam int CFG_AW = 5;

  // Reset values of the registers
  localparam logic [11:0] RST_UPRIGHT_REF  = 12'd2048;
  localparam logic [6:0]  RST_SWING_DRIVE  = 7'd35;
  localparam logic [15:0] RST_PULSE_MS     = 16'd100;
  localparam logic [15:0] RST_SAMPLE_MS    = 16'd40;
  localparam logic [15:0] RST_PRECHECK_MS  = 16'd40;
  localparam logic [10:0] RST_CENTER_RANGE = 11'd500;
  localparam logic [10:0] RST_BOTTOM_RANGE = 11'd200;
  localparam logic [15:0] RST_TIMEOUT_MS   = 16'd20000;

  // Drive magnitude limit and balance fall limit
  localparam logic [6:0] DRIVE_LIMIT  = 7'd90;
  localparam int         TOPPLE_LIMIT = 1500;

  // Configuration bundle from register file to core
  typedef struct packed {
    logic [11:0] upright_ref;
    logic [6:0]  swing_drive;
    logic [15:0] pulse_ms;
    logic [15:0] sample_ms;
    logic [15:0] precheck_ms;
    logic [10:0] center_range;
    logic [10:0] bottom_range;
    logic [15:0] timeout_ms;
  } cfg_t;

  // One control tick
  typedef struct packed {
    logic        active;
    logic        toggle;
    logic [15:0] encoder_delta;
    logic [11:0] pend_angle;
    logic [31:0] now_ms;
  } tick_t;

  // One result word
  typedef struct packed {
    logic        balance_active;
    logic        clear_controllers;
    logic [9:0]  shaft_pos;
    logic [12:0] tilt_err;
    logic [7:0]  drive;
    logic [3:0]  swing_phase;
    logic [1:0]  state_code;
  } res_t;

endpackage

FILE: hdl/pendulum_swing_up_sequencer.sv
// Top level of the pendulum swing-up sequencer: stream ports, tick and result registers.
// One control tick word in, one result word out. The block takes one word per clock
// while the output side is not stalled: a word is held in the input register, is
// evaluated by the combinational state update in the core, and lands in the output
// register, from which its result is offered. The figure of one word per clock is
// set by the core's state loop, which is combinational between its state registers.
// While a result waits in the output register, one more tick can still be accepted
// into the input register. Configuration must be written through the APB-style port
// while no ticks are in flight; the block itself does not enforce this.
// Registers sit at byte address 4*index.
module pendulum_swing_up_sequencer
  import psus_pkg::*;
#(
  parameter int ANGLE_BITS    = 12,
  parameter int POSITION_WRAP = 408
) (
  input  logic              clk,
  input  logic              rst_n,
  // tick stream
  input  logic              in_tvalid,
  output logic              in_tready,
  // [31:0] now_ms, [43:32] pend_angle, [59:44] encoder_delta, [60] toggle,
  // [61] active, [63:62] zero
  input  logic [63:0]       in_tdata,
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  // [1:0] state_code, [5:2] swing_phase, [13:6] drive, [26:14] tilt_err,
  // [36:27] shaft_pos, [37] clear_controllers, [38] balance_active, [39] zero
  output logic [39:0]       out_tdata,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t  cfg;
  tick_t tick_r;
  res_t  res;
  logic  in_v_r;
  logic  out_v_r;
  res_t  out_r;
  logic  adv;
  logic  step;

  assign cfg_pready = 1'b1;

  psus_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  psus_core #(
    .ANGLE_BITS    (ANGLE_BITS),
    .POSITION_WRAP (POSITION_WRAP)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg),
    .tick  (tick_r),
    .res   (res)
  );

  // handshake: output register frees up, tick moves on
  assign adv       = !out_v_r || out_tready;
  assign step      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tick_r <= tick_t'(in_tdata[61:0]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_r};

  // balance flag tracks the reported state
  a_bal_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[38] == (out_tdata[1:0] == MODE_BAL)))
    else $error("balance_active disagrees with state_code");

  // only swing-up drives the motor
  a_drive_swing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != MODE_SWING) |-> (out_tdata[13:6] == 8'd0))
    else $error("nonzero drive outside swing-up");

  // a held tick is not lost while the output stalls
  a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !adv) |=> (in_v_r && $stable(tick_r)))
    else $error("stalled tick dropped or changed");

endmodule

FILE: hdl/psus_cfg.sv
// APB-style register file holding the sequencer configuration.
module psus_cfg
  import psus_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  // register writes, upper value bits dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upright_ref  <= RST_UPRIGHT_REF;
      cfg_r.swing_drive  <= RST_SWING_DRIVE;
      cfg_r.pulse_ms     <= RST_PULSE_MS;
      cfg_r.sample_ms    <= RST_SAMPLE_MS;
      cfg_r.precheck_ms  <= RST_PRECHECK_MS;
      cfg_r.center_range <= RST_CENTER_RANGE;
      cfg_r.bottom_range <= RST_BOTTOM_RANGE;
      cfg_r.timeout_ms   <= RST_TIMEOUT_MS;
    end else if (wr_en) begin
      unique case (idx)
        REG_UPRIGHT_REF:  cfg_r.upright_ref  <= pwdata[11:0];
        REG_SWING_DRIVE:  cfg_r.swing_drive  <= pwdata[6:0];
        REG_PULSE_MS:     cfg_r.pulse_ms     <= pwdata[15:0];
        REG_SAMPLE_MS:    cfg_r.sample_ms    <= pwdata[15:0];
        REG_PRECHECK_MS:  cfg_r.precheck_ms  <= pwdata[15:0];
        REG_CENTER_RANGE: cfg_r.center_range <= pwdata[10:0];
        REG_BOTTOM_RANGE: cfg_r.bottom_range <= pwdata[10:0];
        REG_TIMEOUT_MS:   cfg_r.timeout_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_UPRIGHT_REF:  prdata = 32'(cfg_r.upright_ref);
      REG_SWING_DRIVE:  prdata = 32'(cfg_r.swing_drive);
      REG_PULSE_MS:     prdata = 32'(cfg_r.pulse_ms);
      REG_SAMPLE_MS:    prdata = 32'(cfg_r.sample_ms);
      REG_PRECHECK_MS:  prdata = 32'(cfg_r.precheck_ms);
      REG_CENTER_RANGE: prdata = 32'(cfg_r.center_range);
      REG_BOTTOM_RANGE: prdata = 32'(cfg_r.bottom_range);
      REG_TIMEOUT_MS:   prdata = 32'(cfg_r.timeout_ms);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: hdl/psus_core.sv
// Sequencer state and the combinational next-state / result logic for one tick.
module psus_core
  import psus_pkg::*;
#(
  parameter int ANGLE_BITS    = 12,
  parameter int POSITION_WRAP = 408
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  cfg_t  cfg,
  input  tick_t tick,
  output res_t  res
);

  // angle sample width, signed compare width, position widths
  localparam int RW = (ANGLE_BITS < 12) ? ANGLE_BITS : 12;
  localparam int AW = ((ANGLE_BITS > 12) ? ANGLE_BITS : 12) + 3;
  localparam int PW = $clog2(POSITION_WRAP + 1) + 1;
  localparam int SW = ((PW > 16) ? PW : 16) + 1;
  localparam int EW = (PW > 10) ? PW : 10;

  localparam logic signed [AW-1:0] ANG_FULL = AW'((1 << ANGLE_BITS) - 1);
  localparam logic signed [AW-1:0] FALL_HI  = AW'(TOPPLE_LIMIT);
  localparam logic signed [AW-1:0] FALL_LO  = AW'(-TOPPLE_LIMIT);
  localparam logic signed [SW-1:0] WRAP_HI  = SW'(POSITION_WRAP);
  localparam logic signed [SW-1:0] WRAP_LO  = SW'(-POSITION_WRAP);

  mode_t                mode_r, mode_nxt;
  phase_t               phase_r, phase_nxt;
  logic [1:0]           scnt_r, scnt_nxt;
  logic [RW-1:0]        hist_r [3];
  logic [RW-1:0]        hist_nxt [3];
  logic [31:0]          start_r, start_nxt;
  logic [31:0]          pdl_r, pdl_nxt;
  logic [31:0]          sdl_r, sdl_nxt;
  logic signed [PW-1:0] pos_r, pos_nxt;
  logic                 was_r, was_nxt;

  logic [RW-1:0]        raw;
  logic signed [AW-1:0] raw_s, tgt_s, cr_s, br_s, hi_s, lo_s, err_s;
  logic signed [AW-1:0] a0, a1, a2;
  logic signed [SW-1:0] psum;
  logic signed [EW-1:0] pos_ext;
  logic [6:0]           mag;
  logic signed [7:0]    drv_cw, drv_ccw, drive;
  logic                 clr;

  // wrap-safe deadline check
  function automatic logic due(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] d;
    d = now - dl;
    return !d[31];
  endfunction

  assign raw     = tick.pend_angle[RW-1:0];
  assign raw_s   = AW'(raw);
  assign tgt_s   = AW'(cfg.upright_ref);
  assign cr_s    = AW'(cfg.center_range);
  assign br_s    = AW'(cfg.bottom_range);
  assign hi_s    = tgt_s + cr_s;
  assign lo_s    = tgt_s - cr_s;
  assign err_s   = tgt_s - raw_s;
  assign mag     = (cfg.swing_drive > DRIVE_LIMIT) ? DRIVE_LIMIT : cfg.swing_drive;
  assign drv_cw  = 8'(mag);
  assign drv_ccw = -drv_cw;
  assign psum    = SW'(pos_r) + SW'($signed(tick.encoder_delta));

  // one tick of the sequencer
  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    scnt_nxt  = scnt_r;
    hist_nxt  = hist_r;
    start_nxt = start_r;
    pdl_nxt   = pdl_r;
    sdl_nxt   = sdl_r;
    pos_nxt   = pos_r;
    was_nxt   = was_r;
    drive     = '0;
    clr       = 1'b0;
    a0        = '0;
    a1        = '0;
    a2        = '0;

    if (!tick.active) begin
      // leaving active mode clears the block once
      if (was_r) begin
        clr       = 1'b1;
        mode_nxt  = MODE_IDLE;
        phase_nxt = PH_IDLE;
        scnt_nxt  = '0;
        pos_nxt   = '0;
        was_nxt   = 1'b0;
      end
    end else begin
      was_nxt = 1'b1;
      if (psum > WRAP_HI || psum < WRAP_LO) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = PW'(psum);
      end

      // start / stop command
      if (tick.toggle) begin
        clr = 1'b1;
        if (mode_r == MODE_IDLE || mode_r == MODE_FALLEN) begin
          pos_nxt   = '0;
          scnt_nxt  = '0;
          hist_nxt  = '{raw, raw, raw};
          start_nxt = tick.now_ms;
          pdl_nxt   = tick.now_ms + 32'(cfg.precheck_ms);
          phase_nxt = PH_PRE;
          mode_nxt  = MODE_SWING;
        end else begin
          phase_nxt = PH_IDLE;
          mode_nxt  = MODE_IDLE;
          scnt_nxt  = '0;
        end
      end

      unique case (mode_nxt)
        MODE_SWING: begin
          if ((tick.now_ms - start_nxt) >= 32'(cfg.timeout_ms)) begin
            phase_nxt = PH_IDLE;
            mode_nxt  = MODE_FALLEN;
          end else begin
            unique case (phase_nxt)
              PH_PRE: begin
                a0 = AW'(hist_nxt[0]);
                if (due(tick.now_ms, pdl_nxt)) begin
                  if (a0 > lo_s && a0 < hi_s && raw_s > lo_s && raw_s < hi_s) begin
                    clr       = 1'b1;
                    pos_nxt   = '0;
                    scnt_nxt  = '0;
                    phase_nxt = PH_IDLE;
                    mode_nxt  = MODE_BAL;
                  end else if ((a0 <= br_s || a0 >= ANG_FULL - br_s) &&
                               (raw_s <= br_s || raw_s >= ANG_FULL - br_s)) begin
                    start_nxt = tick.now_ms;
                    scnt_nxt  = '0;
                    hist_nxt  = '{raw, raw, raw};
                    phase_nxt = PH_ICW;
                    pdl_nxt   = tick.now_ms + 32'(cfg.pulse_ms);
                    drive     = drv_cw;
                  end else begin
                    scnt_nxt  = '0;
                    phase_nxt = PH_IDLE;
                    mode_nxt  = MODE_IDLE;
                  end
                end
              end
              // first pulse of a pair
              PH_ICW, PH_RCW, PH_LCCW: begin
                drive = (phase_nxt == PH_LCCW) ? drv_ccw : drv_cw;
                if (due(tick.now_ms, pdl_nxt)) begin
                  drive     = (phase_nxt == PH_LCCW) ? drv_cw : drv_ccw;
                  phase_nxt = phase_t'(phase_nxt + 4'd1);
                  pdl_nxt   = tick.now_ms + 32'(cfg.pulse_ms);
                end
              end
              // second pulse of a pair
              PH_ICCW, PH_RCCW, PH_LCW: begin
                drive = (phase_nxt == PH_LCW) ? drv_cw : drv_ccw;
                if (due(tick.now_ms, pdl_nxt)) begin
                  phase_nxt = PH_SCAN;
                  sdl_nxt   = tick.now_ms + 32'(cfg.sample_ms);
                  drive     = '0;
                end
              end
              // three-sample peak scan
              PH_SCAN: begin
                if (due(tick.now_ms, sdl_nxt)) begin
                  sdl_nxt     = tick.now_ms + 32'(cfg.sample_ms);
                  hist_nxt[2] = hist_nxt[1];
                  hist_nxt[1] = hist_nxt[0];
                  hist_nxt[0] = raw;
                  if (scnt_nxt != 2'd3) begin
                    scnt_nxt = scnt_nxt + 2'd1;
                  end
                  a0 = AW'(hist_nxt[0]);
                  a1 = AW'(hist_nxt[1]);
                  a2 = AW'(hist_nxt[2]);
                  if (scnt_nxt >= 2'd2 && a0 > lo_s && a0 < hi_s &&
                      a1 > lo_s && a1 < hi_s) begin
                    clr       = 1'b1;
                    pos_nxt   = '0;
                    phase_nxt = PH_IDLE;
                    mode_nxt  = MODE_BAL;
                  end else if (scnt_nxt == 2'd3 && a0 > hi_s && a1 > hi_s &&
                               a2 > hi_s && a1 < a0 && a1 < a2) begin
                    phase_nxt = PH_RCW;
                    pdl_nxt   = tick.now_ms + 32'(cfg.pulse_ms);
                    drive     = drv_cw;
                  end else if (scnt_nxt == 2'd3 && a0 < lo_s && a1 < lo_s &&
                               a2 < lo_s && a1 > a0 && a1 > a2) begin
                    phase_nxt = PH_LCCW;
                    pdl_nxt   = tick.now_ms + 32'(cfg.pulse_ms);
                    drive     = drv_ccw;
                  end
                end
              end
              // no pump phase yet: go scan
              default: begin
                phase_nxt = PH_SCAN;
                sdl_nxt   = tick.now_ms + 32'(cfg.sample_ms);
              end
            endcase
          end
        end
        MODE_BAL: begin
          if (err_s > FALL_HI || err_s < FALL_LO) begin
            phase_nxt = PH_IDLE;
            mode_nxt  = MODE_FALLEN;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // result word
  assign pos_ext = EW'(pos_nxt);
  always_comb begin
    res                   = '0;
    res.clear_controllers = clr;
    if (tick.active) begin
      res.state_code     = mode_nxt;
      res.swing_phase    = phase_nxt;
      res.drive          = drive;
      res.tilt_err       = err_s[12:0];
      res.shaft_pos      = pos_ext[9:0];
      res.balance_active = (mode_nxt == MODE_BAL);
    end
  end

  // state update once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      phase_r   <= PH_IDLE;
      scnt_r    <= '0;
      hist_r    <= '{'0, '0, '0};
      start_r   <= '0;
      pdl_r     <= '0;
      sdl_r     <= '0;
      pos_r     <= '0;
      was_r     <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      phase_r   <= phase_nxt;
      scnt_r    <= scnt_nxt;
      hist_r    <= hist_nxt;
      start_r   <= start_nxt;
      pdl_r     <= pdl_nxt;
      sdl_r     <= sdl_nxt;
      pos_r     <= pos_nxt;
      was_r     <= was_nxt;
    end
  end

endmodule

FILE: test/tb_pendulum_swing_up_sequencer.sv
// Testbench for the pendulum swing-up sequencer: directed ticks, then random swing episodes.
module tb_pendulum_swing_up_sequencer;
  import psus_pkg::*;

  localparam int POS_WRAP    = 408;
  localparam int HOLD_CYCLES = 60;

  typedef enum int {ZN_BOTTOM, ZN_CENTER, ZN_RIGHT, ZN_LEFT, ZN_FAR} angle_zone_t;
  typedef enum int {CFG_RANDOM, CFG_LOW, CFG_HIGH, CFG_FAST} cfg_kind_t;

  // one row of the directed tick table
  typedef struct packed {
    logic  typed;
    res_t  want;
    tick_t tick;
  } tick_row_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  // [31:0] now_ms, [43:32] pend_angle, [59:44] encoder_delta, [60] toggle,
  // [61] active, [63:62] zero
  logic [63:0]       in_tdata    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  // [1:0] state_code, [5:2] swing_phase, [13:6] drive, [26:14] tilt_err,
  // [36:27] shaft_pos, [37] clear_controllers, [38] balance_active, [39] zero
  logic [39:0]       out_tdata;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // sequencer shadow: configuration and state
  cfg_t        cfg_sh;
  mode_t       md        = MODE_IDLE;
  phase_t      ph        = PH_IDLE;
  logic [1:0]  scnt      = '0;
  logic [11:0] hist [3];
  logic [31:0] t_start   = '0;
  logic [31:0] ph_dl     = '0;
  logic [31:0] smp_dl    = '0;
  int          pos       = 0;
  logic        was_act   = 1'b0;

  res_t        sequencer_outputs [$];
  tick_row_t   tick_table [$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int          hold_asks      = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  logic [31:0] tnow           = '0;

  pendulum_swing_up_sequencer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // wrap-safe deadline test
  function automatic logic deadline_hit(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] d;
    d = now - dl;
    return !d[31];
  endfunction

  function automatic logic centered(input int a);
    int t;
    t = int'(cfg_sh.upright_ref);
    return a > t - int'(cfg_sh.center_range) && a < t + int'(cfg_sh.center_range);
  endfunction

  function automatic logic hanging(input int a);
    return a <= int'(cfg_sh.bottom_range) || a >= 4095 - int'(cfg_sh.bottom_range);
  endfunction

  function automatic res_t mk_res(input mode_t s, input phase_t p, input int drv,
                                  input int err, input int ps, input logic clr,
                                  input logic bal);
    res_t r;
    r.state_code        = s;
    r.swing_phase       = p;
    r.drive             = 8'(drv);
    r.tilt_err          = 13'(err);
    r.shaft_pos         = 10'(ps);
    r.clear_controllers = clr;
    r.balance_active    = bal;
    return r;
  endfunction

  // advance the shadow sequencer by one tick, return its result word
  function automatic res_t step_sequencer(input tick_t t);
    res_t        r;
    logic [31:0] now;
    int          raw, delta, err, hi, lo, mag, drv, dir, tgt, a0, a1, a2;
    logic        clr;
    r   = '0;
    drv = 0;
    clr = 1'b0;
    now = t.now_ms;
    raw = int'(t.pend_angle);
    delta = int'($signed(t.encoder_delta));

    // leaving active mode clears the block
    if (!t.active) begin
      if (was_act) begin
        clr = 1'b1;
        md = MODE_IDLE;
        ph = PH_IDLE;
        scnt = '0;
        pos = 0;
        was_act = 1'b0;
      end
      r.clear_controllers = clr;
      return r;
    end
    was_act = 1'b1;

    // motor position, snaps to zero beyond one revolution
    pos += delta;
    if (pos > POS_WRAP || pos < -POS_WRAP) pos = 0;

    // start / stop command
    if (t.toggle) begin
      clr = 1'b1;
      if (md == MODE_IDLE || md == MODE_FALLEN) begin
        pos = 0;
        scnt = '0;
        hist[0] = t.pend_angle;
        hist[1] = t.pend_angle;
        hist[2] = t.pend_angle;
        t_start = now;
        ph_dl = now + 32'(cfg_sh.precheck_ms);
        ph = PH_PRE;
        md = MODE_SWING;
      end else begin
        ph = PH_IDLE;
        md = MODE_IDLE;
        scnt = '0;
      end
    end

    tgt = int'(cfg_sh.upright_ref);
    err = tgt - raw;
    hi  = tgt + int'(cfg_sh.center_range);
    lo  = tgt - int'(cfg_sh.center_range);
    mag = (cfg_sh.swing_drive > DRIVE_LIMIT) ? int'(DRIVE_LIMIT) : int'(cfg_sh.swing_drive);

    case (md)
      MODE_SWING: begin
        if (now - t_start >= 32'(cfg_sh.timeout_ms)) begin
          ph = PH_IDLE;
          md = MODE_FALLEN;
        end else begin
          case (ph)
            PH_PRE: begin
              if (deadline_hit(now, ph_dl)) begin
                if (centered(int'(hist[0])) && centered(raw)) begin
                  clr = 1'b1;
                  pos = 0;
                  scnt = '0;
                  ph = PH_IDLE;
                  md = MODE_BAL;
                end else if (hanging(int'(hist[0])) && hanging(raw)) begin
                  t_start = now;
                  scnt = '0;
                  hist[0] = t.pend_angle;
                  hist[1] = t.pend_angle;
                  hist[2] = t.pend_angle;
                  ph = PH_ICW;
                  ph_dl = now + 32'(cfg_sh.pulse_ms);
                  drv = mag;
                end else begin
                  scnt = '0;
                  ph = PH_IDLE;
                  md = MODE_IDLE;
                end
              end
            end
            PH_ICW, PH_RCW, PH_LCCW: begin
              dir = (ph == PH_LCCW) ? -1 : 1;
              drv = dir * mag;
              if (deadline_hit(now, ph_dl)) begin
                ph = phase_t'(ph + 4'd1);
                ph_dl = now + 32'(cfg_sh.pulse_ms);
                drv = -dir * mag;
              end
            end
            PH_ICCW, PH_RCCW, PH_LCW: begin
              drv = (ph == PH_LCW) ? mag : -mag;
              if (deadline_hit(now, ph_dl)) begin
                ph = PH_SCAN;
                smp_dl = now + 32'(cfg_sh.sample_ms);
                drv = 0;
              end
            end
            PH_SCAN: begin
              // three-sample peak scan
              if (deadline_hit(now, smp_dl)) begin
                smp_dl = now + 32'(cfg_sh.sample_ms);
                hist[2] = hist[1];
                hist[1] = hist[0];
                hist[0] = t.pend_angle;
                if (scnt < 2'd3) scnt = scnt + 2'd1;
                a0 = int'(hist[0]);
                a1 = int'(hist[1]);
                a2 = int'(hist[2]);
                if (scnt >= 2'd2 && centered(a0) && centered(a1)) begin
                  clr = 1'b1;
                  pos = 0;
                  ph = PH_IDLE;
                  md = MODE_BAL;
                end else if (scnt == 2'd3 && a0 > hi && a1 > hi && a2 > hi &&
                             a1 < a0 && a1 < a2) begin
                  ph = PH_RCW;
                  ph_dl = now + 32'(cfg_sh.pulse_ms);
                  drv = mag;
                end else if (scnt == 2'd3 && a0 < lo && a1 < lo && a2 < lo &&
                             a1 > a0 && a1 > a2) begin
                  ph = PH_LCCW;
                  ph_dl = now + 32'(cfg_sh.pulse_ms);
                  drv = -mag;
                end
              end
            end
            default: begin
              ph = PH_SCAN;
              smp_dl = now + 32'(cfg_sh.sample_ms);
            end
          endcase
        end
      end
      MODE_BAL: begin
        // fall limit
        if (raw - tgt > TOPPLE_LIMIT || raw - tgt < -TOPPLE_LIMIT) begin
          ph = PH_IDLE;
          md = MODE_FALLEN;
        end
      end
      default: ph = PH_IDLE;
    endcase

    return mk_res(md, ph, drv, err, pos, clr, md == MODE_BAL);
  endfunction

  // drive one tick word; typed rows push their literal result instead of the shadow's
  task automatic send_tick(input tick_t t, input logic typed, input res_t want);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, t};
    do @(posedge clk); while (!in_tready);
    r = step_sequencer(t);
    sequencer_outputs.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // stop sending, wait for all results, then idle for the given extra cycles
  task automatic quiesce(input int extra);
    in_tvalid = 1'b0;
    while (sequencer_outputs.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // APB write: setup then access
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_UPRIGHT_REF:  cfg_sh.upright_ref  = val[11:0];
      REG_SWING_DRIVE:  cfg_sh.swing_drive  = val[6:0];
      REG_PULSE_MS:     cfg_sh.pulse_ms     = val[15:0];
      REG_SAMPLE_MS:    cfg_sh.sample_ms    = val[15:0];
      REG_PRECHECK_MS:  cfg_sh.precheck_ms  = val[15:0];
      REG_CENTER_RANGE: cfg_sh.center_range = val[10:0];
      REG_BOTTOM_RANGE: cfg_sh.bottom_range = val[10:0];
      default:          cfg_sh.timeout_ms   = val[15:0];
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // load all registers; bits above each width carry junk
  task automatic program_regs(input cfg_kind_t kind);
    cfg_t c;
    case (kind)
      CFG_LOW: c = '0;
      CFG_HIGH: begin
        c.upright_ref  = 12'd4095;
        c.swing_drive  = 7'd100;
        c.pulse_ms     = '1;
        c.sample_ms    = '1;
        c.precheck_ms  = '1;
        c.center_range = '1;
        c.bottom_range = '1;
        c.timeout_ms   = '1;
      end
      CFG_FAST: begin
        // zero durations, saturated drive
        c.upright_ref  = RST_UPRIGHT_REF;
        c.swing_drive  = 7'd100;
        c.pulse_ms     = '0;
        c.sample_ms    = '0;
        c.precheck_ms  = '0;
        c.center_range = RST_CENTER_RANGE;
        c.bottom_range = RST_BOTTOM_RANGE;
        c.timeout_ms   = 16'($urandom_range(20000, 3000));
      end
      default: begin
        c.upright_ref  = 12'($urandom_range(2600, 1500));
        c.swing_drive  = 7'($urandom_range(100, 0));
        c.pulse_ms     = 16'($urandom_range(300, 1));
        c.sample_ms    = 16'($urandom_range(100, 1));
        c.precheck_ms  = 16'($urandom_range(100, 1));
        c.center_range = 11'($urandom_range(800, 50));
        c.bottom_range = 11'($urandom_range(600, 0));
        c.timeout_ms   = 16'($urandom_range(65535, 500));
      end
    endcase
    write_reg(REG_UPRIGHT_REF,  {20'($urandom()), c.upright_ref});
    write_reg(REG_SWING_DRIVE,  {25'($urandom()), c.swing_drive});
    write_reg(REG_PULSE_MS,     {16'($urandom()), c.pulse_ms});
    write_reg(REG_SAMPLE_MS,    {16'($urandom()), c.sample_ms});
    write_reg(REG_PRECHECK_MS,  {16'($urandom()), c.precheck_ms});
    write_reg(REG_CENTER_RANGE, {21'($urandom()), c.center_range});
    write_reg(REG_BOTTOM_RANGE, {21'($urandom()), c.bottom_range});
    write_reg(REG_TIMEOUT_MS,   {16'($urandom()), c.timeout_ms});
  endtask

  // angle inside a zone of the current setting, any angle if the zone is empty
  function automatic logic [11:0] pick_angle(input angle_zone_t z);
    int tgt, cr, br, lo_b, hi_b;
    tgt  = int'(cfg_sh.upright_ref);
    cr   = int'(cfg_sh.center_range);
    br   = int'(cfg_sh.bottom_range);
    lo_b = 0;
    hi_b = 4095;
    case (z)
      ZN_BOTTOM: begin
        if ($urandom_range(1) == 0) hi_b = br;
        else lo_b = 4095 - br;
      end
      ZN_CENTER: begin
        lo_b = tgt - cr + 1;
        hi_b = tgt + cr - 1;
      end
      ZN_RIGHT: lo_b = tgt + cr + 1;
      ZN_LEFT:  hi_b = tgt - cr - 1;
      default: ;
    endcase
    if (lo_b < 0) lo_b = 0;
    if (hi_b > 4095) hi_b = 4095;
    if (lo_b > hi_b) begin
      lo_b = 0;
      hi_b = 4095;
    end
    return 12'($urandom_range(hi_b, lo_b));
  endfunction

  // time step scaled to the longest configured duration
  function automatic logic [31:0] next_step();
    int d, r;
    d = int'(cfg_sh.pulse_ms);
    if (int'(cfg_sh.sample_ms) > d) d = int'(cfg_sh.sample_ms);
    if (int'(cfg_sh.precheck_ms) > d) d = int'(cfg_sh.precheck_ms);
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(d / 2 + 1, 0);
    if (r < 80) return $urandom_range(d + d / 4 + 1, d / 2);
    if (r < 95) return $urandom_range(3, 0);
    return $urandom();
  endfunction

  // random ticks: mostly swing-up episodes with sticky angle zones, some noise
  task automatic run_random(input int count);
    tick_t       t;
    angle_zone_t zone;
    int          left, r, d;
    left = 0;
    zone = ZN_BOTTOM;
    for (int k = 0; k < count; k++) begin
      t = '0;
      if ($urandom_range(99) < 12) begin
        t.now_ms        = $urandom();
        t.pend_angle    = 12'($urandom());
        t.encoder_delta = 16'($urandom());
        t.toggle        = ($urandom_range(9) == 0);
        t.active        = ($urandom_range(5) != 0);
      end else begin
        if (left == 0) begin
          // new episode
          left = $urandom_range(60, 8);
          r = $urandom_range(99);
          zone = (r < 70) ? ZN_BOTTOM : (r < 85) ? ZN_CENTER : ZN_FAR;
          if (md == MODE_IDLE || md == MODE_FALLEN) t.toggle = 1'b1;
          if ($urandom_range(3) == 0) tnow = 32'hFFFF_FFFF - $urandom_range(2000, 0);
        end else begin
          left--;
          tnow += next_step();
          if ($urandom_range(99) < 20) begin
            r = $urandom_range(99);
            zone = (r < 30) ? ZN_RIGHT : (r < 60) ? ZN_LEFT : (r < 80) ? ZN_CENTER :
                   (r < 90) ? ZN_BOTTOM : ZN_FAR;
          end
          t.toggle = ($urandom_range(99) < 2);
        end
        d = $urandom_range(400, 0) - 200;
        t.active        = ($urandom_range(99) >= 2);
        t.now_ms        = tnow;
        t.pend_angle    = pick_angle(zone);
        t.encoder_delta = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'(d);
      end
      send_tick(t, 1'b0, '0);
    end
  endtask

  task automatic add_row(input logic [31:0] now, input int ang, input int dlt,
                         input logic tgl, input logic act, input logic typed,
                         input res_t want);
    tick_row_t row;
    row.typed              = typed;
    row.want               = want;
    row.tick.now_ms        = now;
    row.tick.pend_angle    = 12'(ang);
    row.tick.encoder_delta = 16'(dlt);
    row.tick.toggle        = tgl;
    row.tick.active        = act;
    tick_table.push_back(row);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[38:0]);
      if (sequencer_outputs.size() == 0) begin
        $display("%0t unexpected result word: expected none actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = sequencer_outputs.pop_front();
        check_field("state_code", want.state_code, got.state_code);
        check_field("swing_phase", want.swing_phase, got.swing_phase);
        check_field("drive", want.drive, got.drive);
        check_field("tilt_err", want.tilt_err, got.tilt_err);
        check_field("shaft_pos", want.shaft_pos, got.shaft_pos);
        check_field("clear_controllers", want.clear_controllers, got.clear_controllers);
        check_field("balance_active", want.balance_active, got.balance_active);
        check_field("pad", 0, out_tdata[39]);
      end
    end
  end

  // main sequence
  initial begin
    logic [31:0] base;
    base = 32'hFFFF_FFD0;
    cfg_sh.upright_ref  = RST_UPRIGHT_REF;
    cfg_sh.swing_drive  = RST_SWING_DRIVE;
    cfg_sh.pulse_ms     = RST_PULSE_MS;
    cfg_sh.sample_ms    = RST_SAMPLE_MS;
    cfg_sh.precheck_ms  = RST_PRECHECK_MS;
    cfg_sh.center_range = RST_CENTER_RANGE;
    cfg_sh.bottom_range = RST_BOTTOM_RANGE;
    cfg_sh.timeout_ms   = RST_TIMEOUT_MS;
    hist[0] = '0;
    hist[1] = '0;
    hist[2] = '0;

    // directed ticks under reset settings, swing-up starting just before the timestamp wraps
    add_row(0, 0, 0, 0, 0, 1, '0);
    add_row(0, 0, 32767, 0, 1, 1, mk_res(MODE_IDLE, PH_IDLE, 0, 2048, 0, 0, 0));
    add_row(5, 4095, 408, 0, 1, 1, mk_res(MODE_IDLE, PH_IDLE, 0, -2047, 408, 0, 0));
    add_row(base, 100, -32768, 1, 1, 0, '0);       // start from hanging
    add_row(base + 40, 4000, 7, 0, 1, 0, '0);      // precheck passes, initial CW
    add_row(base + 140, 4000, -7, 0, 1, 0, '0);    // initial CCW
    add_row(base + 240, 4000, 3, 0, 1, 0, '0);     // scan
    add_row(base + 280, 3000, 0, 0, 1, 0, '0);
    add_row(base + 320, 2900, 0, 0, 1, 0, '0);
    add_row(base + 360, 2950, 0, 0, 1, 0, '0);     // right peak
    add_row(base + 460, 2950, 5, 0, 1, 0, '0);
    add_row(base + 560, 2950, 5, 0, 1, 0, '0);
    add_row(base + 600, 1000, 0, 0, 1, 0, '0);
    add_row(base + 640, 1100, 0, 0, 1, 0, '0);
    add_row(base + 680, 1050, 0, 0, 1, 0, '0);     // left peak
    add_row(base + 780, 1050, -9, 0, 1, 0, '0);
    add_row(base + 880, 1050, -9, 0, 1, 0, '0);
    add_row(base + 920, 2000, 0, 0, 1, 0, '0);
    add_row(base + 960, 2100, 0, 0, 1, 0, '0);     // captured, balancing
    add_row(base + 965, 3600, 11, 0, 1, 0, '0);    // beyond fall limit
    add_row(base + 1000, 2048, 0, 1, 1, 0, '0);    // restart from fallen
    add_row(base + 1040, 2048, 0, 0, 1, 0, '0);    // precheck already upright
    add_row(base + 1045, 2048, 0, 1, 1, 0, '0);    // stop while balancing
    add_row(base + 4000, 100, 0, 1, 1, 0, '0);
    add_row(base + 24000, 100, 0, 0, 1, 0, '0);    // timeout exactly reached
    add_row(base + 24005, 100, 0, 0, 0, 1, mk_res(MODE_IDLE, PH_IDLE, 0, 0, 0, 1, 0));

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 10;
    recv_idle_pct = 72;
    foreach (tick_table[i]) send_tick(tick_table[i].tick, tick_table[i].typed, tick_table[i].want);

    // random segments, each under its own setting
    for (int seg = 0; seg < 6; seg++) begin
      quiesce(4);
      send_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 72 : 0;
      recv_idle_pct = (seg < 2) ? 72 : (seg < 4) ? 10 : 0;
      case (seg)
        1:       program_regs(CFG_LOW);
        3:       program_regs(CFG_HIGH);
        5:       program_regs(CFG_FAST);
        default: program_regs(CFG_RANDOM);
      endcase
      if (seg == 4) hold_asks++;
      if (seg == 5) begin
        run_random(37);
        quiesce(0);
        run_random(38);
      end else begin
        run_random(75);
      end
    end

    quiesce(8);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
